[hdl/porc_pkg.sv]
package porc_pkg;

  // Field widths.
  localparam int ANGLE_W = 16;
  localparam int POS_W   = 18;
  localparam int HOFF_W  = 17;
  localparam int OFFS_W  = 19;
  localparam int ROT_W   = POS_W + 2;
  localparam int SUM_W   = ROT_W + 1;
  localparam int HS_W    = ANGLE_W + 3;

  // Shared multiplier operand width and product width.
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;

  localparam int TRIG_BITS_DEF = 16;

  // Angles in hundredths of a degree.
  localparam int FULL_TURN    = 36000;
  localparam int HALF_TURN    = 18000;
  localparam int QUARTER_TURN = 9000;
  localparam int EIGHTH_TURN  = 4500;

  // Radians per hundredth of a degree in unsigned Q0.32.
  localparam logic [19:0] RAD_PER_CDEG = 20'd749613;
  localparam logic [32:0] ONE_Q32      = 33'h1_0000_0000;

  localparam int SIN_TERMS = 4;
  localparam int COS_TERMS = 5;

  typedef enum logic {
    FN_SIN,
    FN_COS
  } porc_fn_t;

  // Division by a small constant: q ~ (v * m) >> sh, low by at most one.
  typedef struct packed {
    logic [6:0]  d;
    logic [31:0] m;
    logic [5:0]  sh;
  } porc_div_t;

  localparam porc_div_t SIN_DIV [SIN_TERMS] = '{
    '{7'd72, 32'((64'd1 << 38) / 64'd72), 6'd38},
    '{7'd42, 32'((64'd1 << 37) / 64'd42), 6'd37},
    '{7'd20, 32'((64'd1 << 36) / 64'd20), 6'd36},
    '{7'd6,  32'((64'd1 << 34) / 64'd6),  6'd34}
  };

  localparam porc_div_t COS_DIV [COS_TERMS] = '{
    '{7'd90, 32'((64'd1 << 38) / 64'd90), 6'd38},
    '{7'd56, 32'((64'd1 << 37) / 64'd56), 6'd37},
    '{7'd30, 32'((64'd1 << 36) / 64'd30), 6'd36},
    '{7'd12, 32'((64'd1 << 35) / 64'd12), 6'd35},
    '{7'd2,  32'((64'd1 << 32) / 64'd2),  6'd32}
  };

  typedef struct packed {
    logic                    done;
    logic signed [ROT_W-1:0] rx;
    logic signed [ROT_W-1:0] ry;
  } porc_rot_res_t;

  function automatic porc_div_t div_sel(input porc_fn_t fn, input logic [2:0] k);
    porc_div_t r;
    if (fn == FN_SIN) begin
      r = SIN_DIV[k[1:0]];
    end else if (k < 3'(COS_TERMS)) begin
      r = COS_DIV[k];
    end else begin
      r = COS_DIV[COS_TERMS-1];
    end
    return r;
  endfunction

  function automatic logic signed [OFFS_W-1:0] sat_offs(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(2**(OFFS_W-1) - 1);
    lo = SUM_W'(-(2**(OFFS_W-1)));
    if (v > hi) begin
      return OFFS_W'(hi);
    end else if (v < lo) begin
      return OFFS_W'(lo);
    end
    return OFFS_W'(v);
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(2**(POS_W-1) - 1);
    lo = SUM_W'(-(2**(POS_W-1)));
    if (v > hi) begin
      return POS_W'(hi);
    end else if (v < lo) begin
      return POS_W'(lo);
    end
    return POS_W'(v);
  endfunction

  function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [HS_W-1:0] v);
    logic signed [HS_W-1:0] hi;
    logic signed [HS_W-1:0] lo;
    hi = HS_W'(2**(ANGLE_W-1) - 1);
    lo = HS_W'(-(2**(ANGLE_W-1)));
    if (v > hi) begin
      return ANGLE_W'(hi);
    end else if (v < lo) begin
      return ANGLE_W'(lo);
    end
    return ANGLE_W'(v);
  endfunction

endpackage

[hdl/porc_in_if.sv]
interface porc_in_if;
  import porc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      action;
  logic signed [ANGLE_W-1:0] pose_angle;
  logic signed [POS_W-1:0]   pose_x;
  logic signed [POS_W-1:0]   pose_y;

  modport source (output valid, action, pose_angle, pose_x, pose_y, input ready);
  modport sink   (input valid, action, pose_angle, pose_x, pose_y, output ready);
endinterface

[hdl/porc_out_if.sv]
interface porc_out_if;
  import porc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] corrected_angle;
  logic signed [POS_W-1:0]   corrected_x;
  logic signed [POS_W-1:0]   corrected_y;

  modport source (output valid, corrected_angle, corrected_x, corrected_y, input ready);
  modport sink   (input valid, corrected_angle, corrected_x, corrected_y, output ready);
endinterface

[hdl/porc_mul.sv]
module porc_mul #(
  parameter int W = porc_pkg::MUL_W
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  logic signed [2*W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

[hdl/porc_core.sv]
module porc_core #(
  parameter int TRIG_BITS = porc_pkg::TRIG_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [porc_pkg::HOFF_W-1:0]   heading_offset,
  input  logic signed [porc_pkg::POS_W-1:0]    raw_x,
  input  logic signed [porc_pkg::POS_W-1:0]    raw_y,
  output porc_pkg::porc_rot_res_t              res
);
  import porc_pkg::*;

  localparam int FRAC  = TRIG_BITS - 1;
  localparam int TSH   = 32 - FRAC;
  localparam int ACC_W = POS_W + TRIG_BITS + 1;
  localparam int RED_W = HOFF_W + 1;

  typedef enum logic [4:0] {
    C_IDLE, C_RED, C_X, C_X2, C_TM, C_DIV, C_EST, C_COR, C_SF, C_SR, C_QUAD,
    C_R1, C_R2, C_R3, C_R4, C_R5, C_R6
  } state_t;

  typedef enum logic [1:0] {
    QD_0, QD_90, QD_180, QD_270
  } quad_t;

  state_t                    state_r;
  logic signed [RED_W-1:0]   ang_r;
  quad_t                     quad_r;
  logic                      swap_r;
  logic [31:0]               x_r;
  logic [31:0]               x2_r;
  logic [32:0]               t_r;
  logic [31:0]               v_r;
  logic [31:0]               q_r;
  porc_fn_t                  fn_r;
  logic [2:0]                k_r;
  logic [FRAC-1:0]           sin_r;
  logic [FRAC-1:0]           cos_r;
  logic signed [TRIG_BITS-1:0] s_r;
  logic signed [TRIG_BITS-1:0] c_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ROT_W-1:0]   rx_r;
  logic signed [ROT_W-1:0]   ry_r;
  logic                      done_r;

  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [63:0]               prod_u;
  logic [31:0]               hi32;
  logic [31:0]               lo32;

  logic                      red_done;
  logic [15:0]               ang_u;
  quad_t                     quad;
  logic [13:0]               rem_a;
  logic                      swap;
  logic [12:0]               rb;

  porc_div_t                 div;
  logic [31:0]               q0;
  logic [32:0]               rem_c;
  logic [31:0]               q_fin;
  logic [32:0]               t_new;
  logic                      last_term;

  logic signed [TRIG_BITS-1:0] bs;
  logic signed [TRIG_BITS-1:0] bc;
  logic signed [TRIG_BITS-1:0] s_nxt;
  logic signed [TRIG_BITS-1:0] c_nxt;

  function automatic logic [FRAC-1:0] to_trig(input logic [32:0] q);
    logic [33:0] sum;
    logic [33:0] shv;
    sum = 34'(q) + (34'd1 << (TSH - 1));
    shv = sum >> TSH;
    if (shv > 34'((64'd1 << FRAC) - 64'd1)) begin
      return '1;
    end
    return FRAC'(shv);
  endfunction

  function automatic logic signed [ROT_W-1:0] rnd(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] w;
    w = a + (ACC_W'(1) <<< (FRAC - 1));
    return ROT_W'(w >>> FRAC);
  endfunction

  porc_mul #(.W(MUL_W)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign prod_u = prod[63:0];
  assign hi32   = prod[63:32];
  assign lo32   = prod[31:0];

  // Range reduction leaves the angle in 0..35999; split into quadrant and base angle.
  assign red_done = !ang_r[RED_W-1] && (ang_r < RED_W'(FULL_TURN));
  assign ang_u    = ang_r[15:0];

  always_comb begin
    if (ang_u >= 16'(3 * QUARTER_TURN)) begin
      quad  = QD_270;
      rem_a = 14'(ang_u - 16'(3 * QUARTER_TURN));
    end else if (ang_u >= 16'(2 * QUARTER_TURN)) begin
      quad  = QD_180;
      rem_a = 14'(ang_u - 16'(2 * QUARTER_TURN));
    end else if (ang_u >= 16'(QUARTER_TURN)) begin
      quad  = QD_90;
      rem_a = 14'(ang_u - 16'(QUARTER_TURN));
    end else begin
      quad  = QD_0;
      rem_a = 14'(ang_u);
    end
    swap = rem_a > 14'(EIGHTH_TURN);
    rb   = swap ? 13'(14'(QUARTER_TURN) - rem_a) : 13'(rem_a);
  end

  // Series step: t = 1 - (x^2 * t) / d, the division corrected by one compare.
  assign div       = div_sel(fn_r, k_r);
  assign q0        = 32'(prod_u >> div.sh);
  assign rem_c     = {1'b0, v_r} - prod[32:0];
  assign q_fin     = q_r + 32'(rem_c >= 33'(div.d));
  assign t_new     = ONE_Q32 - 33'(q_fin);
  assign last_term = (fn_r == FN_SIN) ? (k_r == 3'(SIN_TERMS - 1))
                                      : (k_r == 3'(COS_TERMS - 1));

  always_comb begin
    bs = swap_r ? $signed({1'b0, cos_r}) : $signed({1'b0, sin_r});
    bc = swap_r ? $signed({1'b0, sin_r}) : $signed({1'b0, cos_r});
    case (quad_r)
      QD_0: begin
        s_nxt = bs;
        c_nxt = bc;
      end
      QD_90: begin
        s_nxt = bc;
        c_nxt = -bs;
      end
      QD_180: begin
        s_nxt = -bs;
        c_nxt = -bc;
      end
      default: begin
        s_nxt = -bc;
        c_nxt = bs;
      end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      C_RED: begin
        mul_a = MUL_W'(rb);
        mul_b = MUL_W'(RAD_PER_CDEG);
      end
      C_X: begin
        mul_a = MUL_W'(lo32);
        mul_b = MUL_W'(lo32);
      end
      C_TM: begin
        mul_a = MUL_W'(x2_r);
        mul_b = MUL_W'(t_r);
      end
      C_DIV: begin
        mul_a = MUL_W'(hi32);
        mul_b = MUL_W'(div.m);
      end
      C_EST: begin
        mul_a = MUL_W'(q0);
        mul_b = MUL_W'(div.d);
      end
      C_SF: begin
        mul_a = MUL_W'(x_r);
        mul_b = MUL_W'(t_r);
      end
      C_R1: begin
        mul_a = MUL_W'(raw_x);
        mul_b = MUL_W'(c_r);
      end
      C_R2: begin
        mul_a = MUL_W'(raw_y);
        mul_b = MUL_W'(s_r);
      end
      C_R3: begin
        mul_a = MUL_W'(raw_x);
        mul_b = MUL_W'(s_r);
      end
      C_R4: begin
        mul_a = MUL_W'(raw_y);
        mul_b = MUL_W'(c_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == C_R6);
      case (state_r)
        C_IDLE: begin
          if (start) begin
            ang_r   <= -RED_W'(heading_offset);
            state_r <= C_RED;
          end
        end
        C_RED: begin
          if (ang_r[RED_W-1]) begin
            ang_r <= ang_r + RED_W'(FULL_TURN);
          end else if (!red_done) begin
            ang_r <= ang_r - RED_W'(FULL_TURN);
          end else begin
            quad_r  <= quad;
            swap_r  <= swap;
            state_r <= C_X;
          end
        end
        C_X: begin
          x_r     <= lo32;
          state_r <= C_X2;
        end
        C_X2: begin
          x2_r    <= hi32;
          t_r     <= ONE_Q32;
          fn_r    <= FN_SIN;
          k_r     <= '0;
          state_r <= C_TM;
        end
        C_TM: begin
          state_r <= C_DIV;
        end
        C_DIV: begin
          v_r     <= hi32;
          state_r <= C_EST;
        end
        C_EST: begin
          q_r     <= q0;
          state_r <= C_COR;
        end
        C_COR: begin
          t_r <= t_new;
          if (!last_term) begin
            k_r     <= k_r + 3'd1;
            state_r <= C_TM;
          end else if (fn_r == FN_SIN) begin
            state_r <= C_SF;
          end else begin
            cos_r   <= to_trig(t_new);
            state_r <= C_QUAD;
          end
        end
        C_SF: begin
          state_r <= C_SR;
        end
        C_SR: begin
          sin_r   <= to_trig({1'b0, hi32});
          t_r     <= ONE_Q32;
          fn_r    <= FN_COS;
          k_r     <= '0;
          state_r <= C_TM;
        end
        C_QUAD: begin
          s_r     <= s_nxt;
          c_r     <= c_nxt;
          state_r <= C_R1;
        end
        C_R1: begin
          state_r <= C_R2;
        end
        C_R2: begin
          acc_r   <= ACC_W'(prod);
          state_r <= C_R3;
        end
        C_R3: begin
          acc_r   <= acc_r - ACC_W'(prod);
          state_r <= C_R4;
        end
        C_R4: begin
          rx_r    <= rnd(acc_r);
          acc_r   <= ACC_W'(prod);
          state_r <= C_R5;
        end
        C_R5: begin
          acc_r   <= acc_r + ACC_W'(prod);
          state_r <= C_R6;
        end
        C_R6: begin
          ry_r    <= rnd(acc_r);
          state_r <= C_IDLE;
        end
        default: begin
          state_r <= C_IDLE;
        end
      endcase
    end
  end

  assign res.done = done_r;
  assign res.rx   = rx_r;
  assign res.ry   = ry_r;

endmodule

[hdl/pose_offset_rotation_correction.sv]
// Each accepted input word yields one result word; the time taken varies with the
// one to three steps of angle range reduction. A new word is taken only once the
// last result is stored. Every multiplication of the sine and cosine series, the
// divisions by constants and the rotation share one multiplier.
// Reset (synchronous, active low) clears the stored raw pose and the offsets to zero.
module pose_offset_rotation_correction #(
  parameter int TRIG_BITS = porc_pkg::TRIG_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  porc_in_if.sink      in_if,
  porc_out_if.source   out_if
);
  import porc_pkg::*;

  typedef enum logic [1:0] {
    T_IDLE, T_START, T_RUN, T_FIN
  } state_t;

  state_t                     state_r;
  logic signed [ANGLE_W-1:0]  raw_heading_r;
  logic signed [POS_W-1:0]    raw_x_r;
  logic signed [POS_W-1:0]    raw_y_r;
  logic signed [HOFF_W-1:0]   heading_offset_r;
  logic signed [OFFS_W-1:0]   offset_x_r;
  logic signed [OFFS_W-1:0]   offset_y_r;
  logic                       cal_r;
  logic signed [POS_W-1:0]    ref_x_r;
  logic signed [POS_W-1:0]    ref_y_r;
  logic                       out_valid_r;
  logic signed [ANGLE_W-1:0]  out_angle_r;
  logic signed [POS_W-1:0]    out_x_r;
  logic signed [POS_W-1:0]    out_y_r;

  porc_rot_res_t              rot;
  logic                       in_take;
  logic                       out_free;
  logic signed [OFFS_W-1:0]   offset_x_nxt;
  logic signed [OFFS_W-1:0]   offset_y_nxt;
  logic signed [POS_W-1:0]    corr_x;
  logic signed [POS_W-1:0]    corr_y;
  logic signed [HS_W-1:0]     h_sum;
  logic signed [HS_W-1:0]     h_wrap;

  porc_core #(.TRIG_BITS(TRIG_BITS)) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (state_r == T_START),
    .heading_offset (heading_offset_r),
    .raw_x          (raw_x_r),
    .raw_y          (raw_y_r),
    .res            (rot)
  );

  assign in_if.ready = (state_r == T_IDLE);
  assign in_take     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;

  // On a calibration the position offsets are taken from the reference and the
  // freshly rotated raw position, and the result already uses the new offsets.
  assign offset_x_nxt = cal_r ? sat_offs(SUM_W'(ref_x_r) - SUM_W'(rot.rx)) : offset_x_r;
  assign offset_y_nxt = cal_r ? sat_offs(SUM_W'(ref_y_r) - SUM_W'(rot.ry)) : offset_y_r;
  assign corr_x       = sat_pos(SUM_W'(rot.rx) + SUM_W'(offset_x_nxt));
  assign corr_y       = sat_pos(SUM_W'(rot.ry) + SUM_W'(offset_y_nxt));

  // The heading is wrapped by one turn at most, then saturated.
  always_comb begin
    h_sum = HS_W'(raw_heading_r) + HS_W'(heading_offset_r);
    if (h_sum > HS_W'(HALF_TURN)) begin
      h_wrap = h_sum - HS_W'(FULL_TURN);
    end else if (h_sum < HS_W'(-HALF_TURN)) begin
      h_wrap = h_sum + HS_W'(FULL_TURN);
    end else begin
      h_wrap = h_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= T_IDLE;
      raw_heading_r    <= '0;
      raw_x_r          <= '0;
      raw_y_r          <= '0;
      heading_offset_r <= '0;
      offset_x_r       <= '0;
      offset_y_r       <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (state_r == T_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        T_IDLE: begin
          if (in_take) begin
            cal_r <= in_if.action;
            if (in_if.action) begin
              heading_offset_r <= HOFF_W'(in_if.pose_angle) - HOFF_W'(raw_heading_r);
              ref_x_r          <= in_if.pose_x;
              ref_y_r          <= in_if.pose_y;
            end else begin
              raw_heading_r <= in_if.pose_angle;
              raw_x_r       <= in_if.pose_x;
              raw_y_r       <= in_if.pose_y;
            end
            state_r <= T_START;
          end
        end
        T_START: begin
          state_r <= T_RUN;
        end
        T_RUN: begin
          if (rot.done) begin
            state_r <= T_FIN;
          end
        end
        T_FIN: begin
          if (out_free) begin
            offset_x_r  <= offset_x_nxt;
            offset_y_r  <= offset_y_nxt;
            out_angle_r <= sat_angle(h_wrap);
            out_x_r     <= corr_x;
            out_y_r     <= corr_y;
            state_r     <= T_IDLE;
          end
        end
        default: begin
          state_r <= T_IDLE;
        end
      endcase
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.corrected_angle = out_angle_r;
  assign out_if.corrected_x     = out_x_r;
  assign out_if.corrected_y     = out_y_r;

endmodule

[tb/tb_top.sv]
module tb_top;
  import porc_pkg::*;

  localparam int     RANDOM_WORDS  = 1850;
  localparam longint CYCLE_LIMIT   = 1_200_000;
  localparam int     SETTLE_CYCLES = 150;
  localparam int     HOLD_CYCLES   = 400;

  localparam int          TRIG_FRAC  = TRIG_BITS_DEF - 1;
  localparam int          TRIG_SH    = 32 - TRIG_FRAC;
  localparam logic [63:0] RAD_Q32    = 64'd749613;
  localparam logic [63:0] UNIT_Q32   = 64'h1_0000_0000;
  localparam longint      ANGLE_SPAN = 36000;
  localparam longint      ANGLE_HALF = 18000;

  typedef enum logic {
    ACT_SAMPLE    = 1'b0,
    ACT_CALIBRATE = 1'b1
  } pose_action_t;

  typedef struct {
    pose_action_t              action;
    logic signed [ANGLE_W-1:0] angle;
    logic signed [POS_W-1:0]   x;
    logic signed [POS_W-1:0]   y;
  } pose_word_t;

  typedef struct {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [POS_W-1:0]   x;
    logic signed [POS_W-1:0]   y;
  } pose_fix_t;

  logic clk;
  logic rst_n;

  porc_in_if  in_bus ();
  porc_out_if out_bus ();

  pose_offset_rotation_correction u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  // Stored transform as the block should hold it.
  logic signed [ANGLE_W-1:0] held_heading;
  logic signed [POS_W-1:0]   held_x;
  logic signed [POS_W-1:0]   held_y;
  logic signed [HOFF_W-1:0]  turn_offset;
  logic signed [OFFS_W-1:0]  shift_x;
  logic signed [OFFS_W-1:0]  shift_y;

  pose_word_t pose_words[$];
  pose_fix_t  corrected_due[$];
  pose_word_t offered;

  int     words_accepted;
  int     results_checked;
  int     mismatches;
  int     n_calibrations;
  int     n_offset_sat;
  int     n_out_sat;
  int     n_wraps;
  longint cycle_count;
  logic   in_taken;
  int     send_gap;
  int     recv_stall;
  logic   hold_off;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] mul_q32(logic [63:0] a, logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 32;
  endfunction

  function automatic longint trig_round(logic [63:0] q32);
    logic [63:0] v;
    v = (q32 + (64'd1 << (TRIG_SH - 1))) >> TRIG_SH;
    if (v > (64'd1 << TRIG_FRAC) - 64'd1) begin
      v = (64'd1 << TRIG_FRAC) - 64'd1;
    end
    return longint'(v);
  endfunction

  // Horner series over 0..45 degrees, every step truncated in Q32.
  function automatic longint series_sin(longint r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = 64'(r) * RAD_Q32;
    x2 = mul_q32(x, x);
    t  = UNIT_Q32 - mul_q32(x2, UNIT_Q32) / 64'd72;
    t  = UNIT_Q32 - mul_q32(x2, t) / 64'd42;
    t  = UNIT_Q32 - mul_q32(x2, t) / 64'd20;
    t  = UNIT_Q32 - mul_q32(x2, t) / 64'd6;
    return trig_round(mul_q32(x, t));
  endfunction

  function automatic longint series_cos(longint r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    x  = 64'(r) * RAD_Q32;
    x2 = mul_q32(x, x);
    t  = UNIT_Q32 - mul_q32(x2, UNIT_Q32) / 64'd90;
    t  = UNIT_Q32 - mul_q32(x2, t) / 64'd56;
    t  = UNIT_Q32 - mul_q32(x2, t) / 64'd30;
    t  = UNIT_Q32 - mul_q32(x2, t) / 64'd12;
    t  = UNIT_Q32 - mul_q32(x2, t) / 64'd2;
    return trig_round(t);
  endfunction

  task automatic sin_cos(input longint a, output longint s, output longint c);
    longint m;
    longint q;
    longint r;
    longint bs;
    longint bc;
    m = ((a % ANGLE_SPAN) + ANGLE_SPAN) % ANGLE_SPAN;
    q = m / 9000;
    r = m % 9000;
    if (r <= 4500) begin
      bs = series_sin(r);
      bc = series_cos(r);
    end else begin
      bs = series_cos(9000 - r);
      bc = series_sin(9000 - r);
    end
    case (q)
      0: begin s = bs;  c = bc;  end
      1: begin s = bc;  c = -bs; end
      2: begin s = -bs; c = -bc; end
      default: begin s = -bc; c = bs; end
    endcase
  endtask

  function automatic longint saturate(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Held position rotated by minus the heading offset, rounded half up.
  task automatic rotate_held(output longint rx, output longint ry);
    longint s;
    longint c;
    sin_cos(-longint'(turn_offset), s, c);
    rx = (longint'(held_x) * c - longint'(held_y) * s + (longint'(1) << (TRIG_FRAC - 1)))
         >>> TRIG_FRAC;
    ry = (longint'(held_x) * s + longint'(held_y) * c + (longint'(1) << (TRIG_FRAC - 1)))
         >>> TRIG_FRAC;
  endtask

  task automatic correct_pose(input pose_word_t w);
    longint    rx;
    longint    ry;
    longint    ox;
    longint    oy;
    longint    h;
    longint    sx;
    longint    sy;
    pose_fix_t fix;
    if (w.action == ACT_SAMPLE) begin
      held_heading = w.angle;
      held_x       = w.x;
      held_y       = w.y;
    end else begin
      n_calibrations++;
      turn_offset = HOFF_W'(longint'(w.angle) - longint'(held_heading));
      rotate_held(rx, ry);
      ox = longint'(w.x) - rx;
      oy = longint'(w.y) - ry;
      if (saturate(ox, OFFS_W) != ox || saturate(oy, OFFS_W) != oy) n_offset_sat++;
      shift_x = OFFS_W'(saturate(ox, OFFS_W));
      shift_y = OFFS_W'(saturate(oy, OFFS_W));
    end
    rotate_held(rx, ry);
    h = longint'(held_heading) + longint'(turn_offset);
    if (h > ANGLE_HALF) begin
      h -= ANGLE_SPAN;
      n_wraps++;
    end else if (h < -ANGLE_HALF) begin
      h += ANGLE_SPAN;
      n_wraps++;
    end
    sx = rx + longint'(shift_x);
    sy = ry + longint'(shift_y);
    if (saturate(sx, POS_W) != sx || saturate(sy, POS_W) != sy) n_out_sat++;
    fix.angle = ANGLE_W'(saturate(h, ANGLE_W));
    fix.x     = POS_W'(saturate(sx, POS_W));
    fix.y     = POS_W'(saturate(sy, POS_W));
    corrected_due.push_back(fix);
  endtask

  task automatic add_word(pose_action_t a, int ang, int x, int y);
    pose_word_t w;
    w.action = a;
    w.angle  = ANGLE_W'(ang);
    w.x      = POS_W'(x);
    w.y      = POS_W'(y);
    pose_words.push_back(w);
  endtask

  function automatic int rand_angle();
    int k;
    int d;
    case ($urandom_range(0, 9))
      0, 1: return int'(ANGLE_W'($urandom));
      2: begin
        k = $urandom_range(0, 8);
        d = $urandom_range(0, 4);
        return k * 4500 - 18000 + d - 2;
      end
      default: begin
        k = $urandom_range(0, 36000);
        return k - 18000;
      end
    endcase
  endfunction

  function automatic int rand_pos();
    int v;
    case ($urandom_range(0, 9))
      6, 7: begin
        v = $urandom_range(0, 2000);
        return v - 1000;
      end
      8: begin
        case ($urandom_range(0, 3))
          0: return -131072;
          1: return 131071;
          2: return -131071;
          default: return 0;
        endcase
      end
      9: begin
        v = $urandom_range(0, 50);
        return ($urandom_range(0, 1) != 0) ? 131071 - v : v - 131072;
      end
      default: return int'($signed(POS_W'($urandom)));
    endcase
  endfunction

  // Mostly short gaps, a few long ones, and every so often a stretch with none.
  function automatic int pick_gap();
    int r;
    if ((words_accepted / 150) % 5 == 2) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Sender: a word stays on the bus until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!(in_bus.valid && !in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_bus.valid <= 1'b0;
      end else if (pose_words.size() > 0) begin
        offered = pose_words.pop_front();
        in_bus.action     <= offered.action;
        in_bus.pose_angle <= offered.angle;
        in_bus.pose_x     <= offered.x;
        in_bus.pose_y     <= offered.y;
        in_bus.valid      <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_taken = rst_n && in_bus.valid && in_bus.ready;
    if (in_taken) begin
      correct_pose(offered);
      words_accepted++;
    end
  end

  // Receiver stalls.
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_bus.ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_stall = pick_gap();
    end
  end

  always @(posedge clk) begin : watch_results
    pose_fix_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (corrected_due.size() == 0) begin
        $display("%0t: unexpected result word angle=%0d x=%0d y=%0d", $time,
                 out_bus.corrected_angle, out_bus.corrected_x, out_bus.corrected_y);
        mismatches++;
      end else begin
        want = corrected_due.pop_front();
        results_checked++;
        if (out_bus.corrected_angle !== want.angle) begin
          $display("%0t: corrected_angle expected %0d got %0d", $time,
                   want.angle, out_bus.corrected_angle);
          mismatches++;
        end
        if (out_bus.corrected_x !== want.x) begin
          $display("%0t: corrected_x expected %0d got %0d", $time,
                   want.x, out_bus.corrected_x);
          mismatches++;
        end
        if (out_bus.corrected_y !== want.y) begin
          $display("%0t: corrected_y expected %0d got %0d", $time,
                   want.y, out_bus.corrected_y);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, corrected_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Hold the result side off long enough for the block to stall its input.
  initial begin
    hold_off = 1'b0;
    while (words_accepted < 60) @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    pose_word_t last;
    int         i;
    int         ang;
    int         px;
    int         py;

    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.action     = ACT_SAMPLE;
    in_bus.pose_angle = '0;
    in_bus.pose_x     = '0;
    in_bus.pose_y     = '0;
    out_bus.ready     = 1'b0;
    held_heading      = '0;
    held_x            = '0;
    held_y            = '0;
    turn_offset       = '0;
    shift_x           = '0;
    shift_y           = '0;
    words_accepted    = 0;
    results_checked   = 0;
    mismatches        = 0;
    n_calibrations    = 0;
    n_offset_sat      = 0;
    n_out_sat         = 0;
    n_wraps           = 0;
    cycle_count       = 0;
    in_taken          = 1'b0;
    send_gap          = 0;
    recv_stall        = 0;

    // Reset state, field extremes, offset and output saturation both ways.
    add_word(ACT_SAMPLE,    0, 0, 0);
    add_word(ACT_CALIBRATE, 0, 0, 0);
    add_word(ACT_SAMPLE,    32767, 131071, -131072);
    add_word(ACT_SAMPLE,    -32768, -131072, 131071);
    add_word(ACT_SAMPLE,    0, 131071, 131071);
    add_word(ACT_CALIBRATE, -4500, 0, -131072);
    add_word(ACT_SAMPLE,    0, -131072, -131072);
    add_word(ACT_CALIBRATE, -4500, 0, 131071);
    add_word(ACT_SAMPLE,    0, 131071, 131071);
    // Quadrant edges and the octant split, where sine or cosine reach unity.
    add_word(ACT_SAMPLE,    0, 1000, -2000);
    add_word(ACT_CALIBRATE, 9000, 500, 500);
    add_word(ACT_CALIBRATE, 18000, -500, 700);
    add_word(ACT_CALIBRATE, -18000, 0, 0);
    add_word(ACT_CALIBRATE, 4500, 10, 10);
    add_word(ACT_CALIBRATE, 4501, 10, 10);
    add_word(ACT_CALIBRATE, 13500, -10, 20);
    add_word(ACT_CALIBRATE, -9000, 131071, -131072);
    // Heading wrapped once either way, then a sum that still overflows.
    add_word(ACT_SAMPLE,    17000, 300, 400);
    add_word(ACT_CALIBRATE, -18000, 0, 0);
    add_word(ACT_SAMPLE,    18000, 300, 400);
    add_word(ACT_SAMPLE,    -18000, 300, 400);
    add_word(ACT_SAMPLE,    -32768, 5, 5);
    add_word(ACT_CALIBRATE, 32767, 7, 7);
    add_word(ACT_SAMPLE,    32767, -1, -1);
    add_word(ACT_CALIBRATE, 18001, -131072, 131071);

    // Mostly samples; calibrations usually sit close to the last sample.
    last = pose_words[$];
    for (i = 0; i < RANDOM_WORDS; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 9) < 6) begin
          ang = int'(last.angle) + $urandom_range(0, 1000) - 500;
          px  = int'(last.x) + $urandom_range(0, 4000) - 2000;
          py  = int'(last.y) + $urandom_range(0, 4000) - 2000;
          add_word(ACT_CALIBRATE, ang, px, py);
        end else begin
          add_word(ACT_CALIBRATE, rand_angle(), rand_pos(), rand_pos());
        end
      end else begin
        add_word(ACT_SAMPLE, rand_angle(), rand_pos(), rand_pos());
        last = pose_words[$];
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pose_words.size() > 0 || in_bus.valid) @(posedge clk);
    while (corrected_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d words (%0d calibrations), %0d results checked.",
             words_accepted, n_calibrations, results_checked);
    $display("Saturated offsets %0d, saturated positions %0d, wrapped headings %0d.",
             n_offset_sat, n_out_sat, n_wraps);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
